/* design/multi_column_histogram_binner_assert.svh */
// ----------------------------------------------------------------------------
// multi_column_histogram_binner assertion macros
// Shared property wrappers for the checker of the histogram binner.
// ----------------------------------------------------------------------------
`ifndef MULTI_COLUMN_HISTOGRAM_BINNER_ASSERT_SVH
`define MULTI_COLUMN_HISTOGRAM_BINNER_ASSERT_SVH

// same-cycle implication, disabled while rst_sig is high
`define MCHB_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("histogram binner check failed");

// next-cycle implication, disabled while rst_sig is high
`define MCHB_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("histogram binner check failed");

`endif

/* design/mchb_pkg.sv */
// ----------------------------------------------------------------------------
// mchb_pkg
// Constants, codes and controller/datapath types of the histogram binner.
// ----------------------------------------------------------------------------
`default_nettype none

package mchb_pkg;

  // sizing of the block
  localparam int NUM_COLUMNS = 4;
  localparam int MAX_BINS    = 1024;
  localparam int VALUE_BITS  = 16;
  localparam int COUNT_BITS  = 32;

  // fixed field widths of the channels and config port
  localparam int KIND_W      = 2;
  localparam int FIELD_W     = 16;
  localparam int COL_IDX_W   = 2;
  localparam int BIN_IDX_W   = 10;
  localparam int WRITE_W     = 32;
  localparam int READ_W      = 32;
  localparam int MASK_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;
  localparam int SRC_W       = 3;
  localparam int CFG_SRC_W   = 12;
  localparam int PACK_W      = 16;

  // derived sizes
  localparam int COL_BITS   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int BIN_BITS   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int NB_BITS    = $clog2(MAX_BINS + 1);
  localparam int TOTAL_BINS = NUM_COLUMNS * MAX_BINS;
  localparam int ADDR_BITS  = (TOTAL_BINS > 1) ? $clog2(TOTAL_BINS) : 1;
  localparam int PROD_BITS  = VALUE_BITS + NB_BITS;
  localparam int DSH_BITS   = VALUE_BITS + BIN_BITS;
  localparam int STEP_BITS  = $clog2(BIN_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
  localparam logic [CFG_SRC_W-1:0]  SOURCES_RESET = '1;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  // column source codes
  localparam logic [SRC_W-1:0] SRC_PH     = 3'd0;
  localparam logic [SRC_W-1:0] SRC_X      = 3'd1;
  localparam logic [SRC_W-1:0] SRC_Y      = 3'd2;
  localparam logic [SRC_W-1:0] SRC_WEIGHT = 3'd3;

  // config register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOWER   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPPER   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BINS    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic col_first;
    logic col_next;
    logic calc;
    logic div_load;
    logic div_step;
    logic ev_rd;
    logic ev_upd;
    logic acc_rd;
    logic acc_wr;
    logic load_result;
  } mchb_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              addr_ok;
    logic              col_ok;
    logic              col_last;
    logic              div_last;
    logic              clr_last;
    logic              out_free;
  } mchb_sts_t;

endpackage

`default_nettype wire

/* design/mchb_if.sv */
// ----------------------------------------------------------------------------
// mchb_if
// Valid/ready channels for items into and results out of the binner.
// ----------------------------------------------------------------------------
`default_nettype none

interface mchb_item_if;
  logic                              valid;
  logic                              ready;
  logic [mchb_pkg::KIND_W-1:0]       kind;
  logic [mchb_pkg::FIELD_W-1:0]      sum_pulse_height;
  logic [mchb_pkg::FIELD_W-1:0]      pixel_x;
  logic [mchb_pkg::FIELD_W-1:0]      pixel_y;
  logic [mchb_pkg::FIELD_W-1:0]      event_weight;
  logic [mchb_pkg::COL_IDX_W-1:0]    column_index;
  logic [mchb_pkg::BIN_IDX_W-1:0]    bin_index;
  logic [mchb_pkg::WRITE_W-1:0]      write_value;

  modport source (
    output valid, kind, sum_pulse_height, pixel_x, pixel_y, event_weight,
           column_index, bin_index, write_value,
    input  ready
  );
  modport sink (
    input  valid, kind, sum_pulse_height, pixel_x, pixel_y, event_weight,
           column_index, bin_index, write_value,
    output ready
  );
endinterface

interface mchb_result_if;
  logic                           valid;
  logic                           ready;
  logic [mchb_pkg::READ_W-1:0]    read_count;
  logic [mchb_pkg::MASK_W-1:0]    hit_mask;
  logic [mchb_pkg::MASK_W-1:0]    saturated_mask;

  modport source (
    output valid, read_count, hit_mask, saturated_mask,
    input  ready
  );
  modport sink (
    input  valid, read_count, hit_mask, saturated_mask,
    output ready
  );
endinterface

`default_nettype wire

/* design/mchb_ctrl.sv */
// ----------------------------------------------------------------------------
// mchb_ctrl
// Sequencer: clearing pass, item dispatch, per-column binning and result.
// ----------------------------------------------------------------------------
`default_nettype none

module mchb_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire mchb_pkg::mchb_sts_t sts,
  output mchb_pkg::mchb_cmd_t     cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DISPATCH = 4'd2;
  localparam logic [3:0] S_ACC_RD   = 4'd3;
  localparam logic [3:0] S_ACC_WR   = 4'd4;
  localparam logic [3:0] S_CALC     = 4'd5;
  localparam logic [3:0] S_DIVLD    = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_EV_RD    = 4'd8;
  localparam logic [3:0] S_EV_UPD   = 4'd9;
  localparam logic [3:0] S_RET      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.kind)
          mchb_pkg::KIND_EVENT: begin
            cmd.col_first = 1'b1;
            state_next    = S_CALC;
          end
          mchb_pkg::KIND_READ:  state_next = S_ACC_RD;
          mchb_pkg::KIND_WRITE: state_next = S_ACC_WR;
          default:              state_next = S_RET;
        endcase
      end
      S_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = S_RET;
      end
      S_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_next = S_RET;
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_DIVLD;
      end
      S_DIVLD: begin
        if (sts.col_ok) begin
          cmd.div_load = 1'b1;
          state_next   = S_DIV;
        end else if (sts.col_last) begin
          state_next = S_RET;
        end else begin
          cmd.col_next = 1'b1;
          state_next   = S_CALC;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_EV_RD;
        end
      end
      S_EV_RD: begin
        cmd.ev_rd  = 1'b1;
        state_next = S_EV_UPD;
      end
      S_EV_UPD: begin
        cmd.ev_upd = 1'b1;
        if (sts.col_last) begin
          state_next = S_RET;
        end else begin
          cmd.col_next = 1'b1;
          state_next   = S_CALC;
        end
      end
      S_RET: begin
        if (sts.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/mchb_datapath.sv */
// ----------------------------------------------------------------------------
// mchb_datapath
// Config registers, item registers, bin arithmetic, radix-2 divider,
// counter memory and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mchb_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mchb_pkg::mchb_cmd_t                 cmd,
  output mchb_pkg::mchb_sts_t                      sts,
  // config port
  input  wire logic                                cfg_wr_en,
  input  wire logic [mchb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [mchb_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  // item payload
  input  wire logic [mchb_pkg::KIND_W-1:0]         kind,
  input  wire logic [mchb_pkg::FIELD_W-1:0]        sum_pulse_height,
  input  wire logic [mchb_pkg::FIELD_W-1:0]        pixel_x,
  input  wire logic [mchb_pkg::FIELD_W-1:0]        pixel_y,
  input  wire logic [mchb_pkg::FIELD_W-1:0]        event_weight,
  input  wire logic [mchb_pkg::COL_IDX_W-1:0]      column_index,
  input  wire logic [mchb_pkg::BIN_IDX_W-1:0]      bin_index,
  input  wire logic [mchb_pkg::WRITE_W-1:0]        write_value,
  // result register
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic [mchb_pkg::READ_W-1:0]              read_count,
  output logic [mchb_pkg::MASK_W-1:0]              hit_mask,
  output logic [mchb_pkg::MASK_W-1:0]              saturated_mask
);

  // config registers
  logic [mchb_pkg::CFG_SRC_W-1:0]  sources_q;
  logic [mchb_pkg::CFG_DATA_W-1:0] lower_q;
  logic [mchb_pkg::CFG_DATA_W-1:0] upper_q;
  logic [mchb_pkg::CFG_DATA_W-1:0] bins_q;

  // captured item
  logic [mchb_pkg::KIND_W-1:0]     kind_q;
  logic [mchb_pkg::VALUE_BITS-1:0] ph_q;
  logic [mchb_pkg::VALUE_BITS-1:0] x_q;
  logic [mchb_pkg::VALUE_BITS-1:0] y_q;
  logic [mchb_pkg::VALUE_BITS-1:0] wt_q;
  logic [mchb_pkg::COL_IDX_W-1:0]  col_idx_q;
  logic [mchb_pkg::BIN_IDX_W-1:0]  bin_idx_q;
  logic [mchb_pkg::COUNT_BITS-1:0] wval_q;

  // column walk and arithmetic
  logic [mchb_pkg::COL_BITS-1:0]   col;
  logic [mchb_pkg::SRC_W-1:0]      src;
  logic [mchb_pkg::VALUE_BITS-1:0] lo;
  logic [mchb_pkg::VALUE_BITS-1:0] hi;
  logic [mchb_pkg::PACK_W-1:0]     nb_raw;
  logic [mchb_pkg::NB_BITS-1:0]    nb;
  logic [mchb_pkg::VALUE_BITS-1:0] v;
  logic [mchb_pkg::VALUE_BITS-1:0] diff;
  logic                            src_ok;
  logic                            col_ok;
  logic [mchb_pkg::PROD_BITS-1:0]  prod_q;
  logic [mchb_pkg::VALUE_BITS-1:0] den_q;
  logic                            col_ok_q;

  // divider
  logic [mchb_pkg::DSH_BITS-1:0]   rem_q;
  logic [mchb_pkg::DSH_BITS-1:0]   dsh_q;
  logic [mchb_pkg::BIN_BITS-1:0]   quo_q;
  logic [mchb_pkg::STEP_BITS-1:0]  step_q;
  logic                            rem_ge;

  // counter memory
  logic [mchb_pkg::COUNT_BITS-1:0] mem [mchb_pkg::TOTAL_BINS];
  logic [mchb_pkg::COUNT_BITS-1:0] rd_q;
  logic [mchb_pkg::ADDR_BITS-1:0]  clr_cnt;
  logic [mchb_pkg::ADDR_BITS-1:0]  item_addr;
  logic [mchb_pkg::ADDR_BITS-1:0]  ev_addr;
  logic [mchb_pkg::ADDR_BITS-1:0]  rd_addr;
  logic [mchb_pkg::ADDR_BITS-1:0]  wr_addr;
  logic [mchb_pkg::COUNT_BITS-1:0] wr_data;
  logic                            wr_en;
  logic                            rd_en;
  logic                            addr_ok;
  logic                            at_max;

  // event masks
  logic [mchb_pkg::MASK_W-1:0]     hit_acc;
  logic [mchb_pkg::MASK_W-1:0]     sat_acc;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sources_q <= mchb_pkg::SOURCES_RESET;
      lower_q   <= '0;
      upper_q   <= '0;
      bins_q    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mchb_pkg::CFG_SOURCES: sources_q <= cfg_wr_data[mchb_pkg::CFG_SRC_W-1:0];
        mchb_pkg::CFG_LOWER:   lower_q   <= cfg_wr_data;
        mchb_pkg::CFG_UPPER:   upper_q   <= cfg_wr_data;
        mchb_pkg::CFG_BINS:    bins_q    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q    <= kind;
      ph_q      <= sum_pulse_height[mchb_pkg::VALUE_BITS-1:0];
      x_q       <= pixel_x[mchb_pkg::VALUE_BITS-1:0];
      y_q       <= pixel_y[mchb_pkg::VALUE_BITS-1:0];
      wt_q      <= event_weight[mchb_pkg::VALUE_BITS-1:0];
      col_idx_q <= column_index;
      bin_idx_q <= bin_index;
      wval_q    <= write_value[mchb_pkg::COUNT_BITS-1:0];
    end
  end

  // read/write item address
  assign addr_ok = (32'(col_idx_q) < 32'(mchb_pkg::NUM_COLUMNS)) &&
                   (32'(bin_idx_q) < 32'(mchb_pkg::MAX_BINS));
  assign item_addr = mchb_pkg::ADDR_BITS'(col_idx_q) *
                     mchb_pkg::ADDR_BITS'(mchb_pkg::MAX_BINS) +
                     mchb_pkg::ADDR_BITS'(bin_idx_q);

  // column pointer
  always_ff @(posedge clk) begin
    if (cmd.col_first) begin
      col <= '0;
    end else if (cmd.col_next) begin
      col <= col + 1'b1;
    end
  end

  // per-column source, bounds and range check
  always_comb begin
    src    = sources_q[mchb_pkg::SRC_W*col +: mchb_pkg::SRC_W];
    lo     = lower_q[mchb_pkg::PACK_W*col +: mchb_pkg::VALUE_BITS];
    hi     = upper_q[mchb_pkg::PACK_W*col +: mchb_pkg::VALUE_BITS];
    nb_raw = bins_q[mchb_pkg::PACK_W*col +: mchb_pkg::PACK_W];
    nb     = (nb_raw > mchb_pkg::PACK_W'(mchb_pkg::MAX_BINS)) ?
             mchb_pkg::NB_BITS'(mchb_pkg::MAX_BINS) : mchb_pkg::NB_BITS'(nb_raw);
    src_ok = 1'b1;
    unique case (src)
      mchb_pkg::SRC_PH:     v = ph_q;
      mchb_pkg::SRC_X:      v = x_q;
      mchb_pkg::SRC_Y:      v = y_q;
      mchb_pkg::SRC_WEIGHT: v = wt_q;
      default: begin
        v      = '0;
        src_ok = 1'b0;
      end
    endcase
    // bin < bins holds exactly when the value is below the upper bound
    col_ok = src_ok && (hi > lo) && (nb != '0) && (v >= lo) && (v < hi);
    diff   = v - lo;
  end

  // offset times bin count, and range width
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod_q   <= mchb_pkg::PROD_BITS'(diff) * mchb_pkg::PROD_BITS'(nb);
      den_q    <= hi - lo;
      col_ok_q <= col_ok;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_ge = (rem_q >= dsh_q);

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_q  <= mchb_pkg::DSH_BITS'(prod_q);
      dsh_q  <= mchb_pkg::DSH_BITS'(den_q) << (mchb_pkg::BIN_BITS - 1);
      quo_q  <= '0;
      step_q <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quo_q  <= mchb_pkg::BIN_BITS'({quo_q, rem_ge});
      step_q <= step_q + 1'b1;
    end
  end

  assign ev_addr = mchb_pkg::ADDR_BITS'(col) *
                   mchb_pkg::ADDR_BITS'(mchb_pkg::MAX_BINS) +
                   mchb_pkg::ADDR_BITS'(quo_q);

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // memory port selection
  assign at_max = (rd_q == mchb_pkg::COUNT_MAX);
  always_comb begin
    rd_en   = cmd.ev_rd || cmd.acc_rd;
    rd_addr = cmd.ev_rd ? ev_addr : item_addr;
    wr_en   = 1'b0;
    wr_addr = item_addr;
    wr_data = wval_q;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (cmd.ev_upd) begin
      wr_en   = !at_max;
      wr_addr = ev_addr;
      wr_data = rd_q + 1'b1;
    end else if (cmd.acc_wr) begin
      wr_en = addr_ok;
    end
  end

  // counter memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // hit and saturation masks
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_acc <= '0;
      sat_acc <= '0;
    end else if (cmd.ev_upd) begin
      if (at_max) begin
        sat_acc <= sat_acc | (mchb_pkg::MASK_W'(1) << col);
      end else begin
        hit_acc <= hit_acc | (mchb_pkg::MASK_W'(1) << col);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      read_count     <= (kind_q == mchb_pkg::KIND_READ && addr_ok) ?
                        mchb_pkg::READ_W'(rd_q) : '0;
      hit_mask       <= hit_acc;
      saturated_mask <= sat_acc;
    end
  end

  // status
  always_comb begin
    sts          = '0;
    sts.kind     = kind_q;
    sts.addr_ok  = addr_ok;
    sts.col_ok   = col_ok_q;
    sts.col_last = (col == mchb_pkg::COL_BITS'(mchb_pkg::NUM_COLUMNS - 1));
    sts.div_last = (step_q == mchb_pkg::STEP_BITS'(mchb_pkg::BIN_BITS - 1));
    sts.clr_last = (clr_cnt == mchb_pkg::ADDR_BITS'(mchb_pkg::TOTAL_BINS - 1));
    sts.out_free = !result_valid || result_ready;
  end

endmodule

`default_nettype wire

/* design/multi_column_histogram_binner.sv */
// ----------------------------------------------------------------------------
// multi_column_histogram_binner
// Four-column fixed-range histogram binner with saturating bin counters.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NUM_COLUMNS * MAX_BINS
// counters, one counter per cycle, and accepts no item until it ends; config
// writes are taken throughout. Items are handled one at a time. An event visits
// each column in turn; a column that does not count is passed over, and one that
// does runs the shared radix-2 divider, which produces one bin index bit per
// cycle, and then a read-modify-write of the counter memory. The result sits in
// an output register, so the next item is accepted while a result still waits
// to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_column_histogram_binner (
  input  wire logic                              clk,
  input  wire logic                              rst,
  mchb_item_if.sink                              item,
  mchb_result_if.source                          result,
  input  wire logic                              cfg_wr_en,
  input  wire logic [mchb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [mchb_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  mchb_pkg::mchb_cmd_t cmd;
  mchb_pkg::mchb_sts_t sts;
  logic                item_ready;

  assign item.ready = item_ready;

  // sequencer
  mchb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // arithmetic, memory and output register
  mchb_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .kind             (item.kind),
    .sum_pulse_height (item.sum_pulse_height),
    .pixel_x          (item.pixel_x),
    .pixel_y          (item.pixel_y),
    .event_weight     (item.event_weight),
    .column_index     (item.column_index),
    .bin_index        (item.bin_index),
    .write_value      (item.write_value),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .read_count       (result.read_count),
    .hit_mask         (result.hit_mask),
    .saturated_mask   (result.saturated_mask)
  );

endmodule

`default_nettype wire

/* design/mchb_checker.sv */
// ----------------------------------------------------------------------------
// mchb_checker
// Port-level checks of the histogram binner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_column_histogram_binner_assert.svh"

module mchb_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           item_valid,
  input wire logic                           item_ready,
  input wire logic                           result_valid,
  input wire logic                           result_ready,
  input wire logic [mchb_pkg::READ_W-1:0]    read_count,
  input wire logic [mchb_pkg::MASK_W-1:0]    hit_mask,
  input wire logic [mchb_pkg::MASK_W-1:0]    saturated_mask
);

  // a stalled result holds its payload
  `MCHB_ASSERT_NXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(read_count) && $stable(hit_mask) && $stable(saturated_mask))

  // a column either counts or saturates, never both
  `MCHB_ASSERT_IMP(a_masks_disjoint, clk, rst, result_valid, (hit_mask & saturated_mask) == '0)

  // a read result carries no event masks
  `MCHB_ASSERT_IMP(a_read_no_masks, clk, rst, result_valid && (read_count != '0), (hit_mask == '0) && (saturated_mask == '0))

  // clearing pass follows reset
  `MCHB_ASSERT_NXT(a_clear_after_reset, clk, 1'b0, rst, !item_ready)

  // one item in flight at a time
  `MCHB_ASSERT_NXT(a_one_in_flight, clk, rst, item_valid && item_ready, !item_ready)

endmodule

bind multi_column_histogram_binner mchb_checker u_mchb_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .read_count     (result.read_count),
  .hit_mask       (result.hit_mask),
  .saturated_mask (result.saturated_mask)
);

`default_nettype wire

/* dv/multi_column_histogram_binner_tb.sv */
// ----------------------------------------------------------------------------
// multi_column_histogram_binner_tb
// Self-checking bench for the four-column histogram binner. A driver feeds
// event, read and write transactions from a queue; an internal mirror of the
// bin counters and range registers predicts every result, and a monitor
// compares each returned result field by field. The run steps through
// several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_column_histogram_binner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mchb_pkg::*;

  // kind and source codes the package leaves unnamed
  localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;
  localparam logic [SRC_W-1:0]  SRC_OFF_LO = 3'd4;
  localparam logic [SRC_W-1:0]  SRC_OFF_HI = 3'd7;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 88;
  localparam int IDLE_PCT      = 81;
  localparam int BOTH_PCT      = 26;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [FIELD_W-1:0]   ph;
    logic [FIELD_W-1:0]   px;
    logic [FIELD_W-1:0]   py;
    logic [FIELD_W-1:0]   wt;
    logic [COL_IDX_W-1:0] col;
    logic [BIN_IDX_W-1:0] bin;
    logic [WRITE_W-1:0]   wval;
  } bin_item_t;

  typedef struct packed {
    logic [READ_W-1:0] count;
    logic [MASK_W-1:0] hits;
    logic [MASK_W-1:0] sats;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wr_data;

  mchb_item_if   item_ch ();
  mchb_result_if result_ch ();

  multi_column_histogram_binner u_top (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // mirror of the block state
  logic [CFG_SRC_W-1:0]  mirror_sources;
  logic [CFG_DATA_W-1:0] mirror_lower;
  logic [CFG_DATA_W-1:0] mirror_upper;
  logic [CFG_DATA_W-1:0] mirror_nbins;
  logic [COUNT_BITS-1:0] mirror_counts [TOTAL_BINS];

  bin_item_t   pending_items [$];
  bin_result_t due_results [$];
  bin_item_t   on_wire;
  bin_result_t want;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // append one transaction to the driver queue
  function automatic void queue_item(input bin_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // append one prediction to the expected results
  function automatic void queue_result(input bin_result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  // update the mirror with one transaction and return its result
  function automatic bin_result_t tally_item(input bin_item_t it);
    bin_result_t        r;
    logic [FIELD_W-1:0] qty [4];
    logic [SRC_W-1:0]   src;
    logic [PACK_W-1:0]  lo, hi, nb;
    logic [63:0]        off, span, bin;
    int unsigned        addr;
    r = '0;
    qty[0] = it.ph;
    qty[1] = it.px;
    qty[2] = it.py;
    qty[3] = it.wt;
    if (it.kind == KIND_EVENT) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        src = mirror_sources[SRC_W*c +: SRC_W];
        lo  = mirror_lower[PACK_W*c +: PACK_W];
        hi  = mirror_upper[PACK_W*c +: PACK_W];
        nb  = mirror_nbins[PACK_W*c +: PACK_W];
        if (nb > MAX_BINS) nb = PACK_W'(MAX_BINS);
        if (src <= SRC_WEIGHT && hi > lo && nb != 0 && qty[src[1:0]] >= lo) begin
          off  = 64'(qty[src[1:0]]);
          off  = off - 64'(lo);
          span = 64'(hi);
          span = span - 64'(lo);
          bin  = (off * 64'(nb)) / span;
          if (bin < 64'(nb)) begin
            addr = c * MAX_BINS + int'(bin);
            if (mirror_counts[addr] == COUNT_MAX) begin
              r.sats[c] = 1'b1;
            end else begin
              mirror_counts[addr] = mirror_counts[addr] + 1'b1;
              r.hits[c] = 1'b1;
            end
          end
        end
      end
    end else if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
      addr = int'(it.col) * MAX_BINS + int'(it.bin);
      if (it.kind == KIND_READ) begin
        r.count = mirror_counts[addr];
      end else begin
        mirror_counts[addr] = it.wval;
      end
    end
    return r;
  endfunction

  function automatic bin_item_t event_item(input logic [FIELD_W-1:0] ph, px, py, wt);
    bin_item_t it;
    it.kind = KIND_EVENT;
    it.ph   = ph;
    it.px   = px;
    it.py   = py;
    it.wt   = wt;
    it.col  = COL_IDX_W'($urandom);
    it.bin  = BIN_IDX_W'($urandom);
    it.wval = $urandom;
    return it;
  endfunction

  function automatic bin_item_t access_item(input logic [KIND_W-1:0] kind,
                                            input logic [COL_IDX_W-1:0] col,
                                            input logic [BIN_IDX_W-1:0] bin,
                                            input logic [WRITE_W-1:0] wval);
    bin_item_t it;
    it.kind = kind;
    it.ph   = FIELD_W'($urandom);
    it.px   = FIELD_W'($urandom);
    it.py   = FIELD_W'($urandom);
    it.wt   = FIELD_W'($urandom);
    it.col  = col;
    it.bin  = bin;
    it.wval = wval;
    return it;
  endfunction

  // random transaction, steered by the current register settings
  function automatic bin_item_t make_item();
    bin_item_t          it;
    int unsigned        pick;
    logic [SRC_W-1:0]   src;
    logic [PACK_W-1:0]  lo, hi, nb;
    int                 near, span_i;
    it.kind = KIND_EVENT;
    it.ph   = FIELD_W'($urandom);
    it.px   = FIELD_W'($urandom);
    it.py   = FIELD_W'($urandom);
    it.wt   = FIELD_W'($urandom);
    it.col  = COL_IDX_W'($urandom);
    it.bin  = BIN_IDX_W'($urandom);
    it.wval = $urandom;
    pick = $urandom_range(99);
    if (pick < 3) it.kind = KIND_NOP;
    else if (pick < 17) it.kind = KIND_READ;
    else if (pick < 30) it.kind = KIND_WRITE;
    // reads and writes mostly land on bins in use
    if (it.kind != KIND_EVENT && $urandom_range(3) != 0) begin
      nb = mirror_nbins[PACK_W*it.col +: PACK_W];
      if (nb > MAX_BINS) nb = PACK_W'(MAX_BINS);
      if (nb != 0) it.bin = BIN_IDX_W'($urandom_range(int'(nb) - 1));
    end
    // preload counts close to the limit so later events saturate
    if (it.kind == KIND_WRITE && $urandom_range(2) == 0) begin
      it.wval = COUNT_MAX - $urandom_range(2);
    end
    // event quantities mostly inside the range of a column that uses them
    if (it.kind == KIND_EVENT) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        src = mirror_sources[SRC_W*c +: SRC_W];
        lo  = mirror_lower[PACK_W*c +: PACK_W];
        hi  = mirror_upper[PACK_W*c +: PACK_W];
        if (src <= SRC_WEIGHT && hi > lo && $urandom_range(9) != 0) begin
          span_i = int'(hi) - int'(lo);
          pick = $urandom_range(19);
          if (pick == 0) near = int'(lo) - 1 - int'($urandom_range(2));
          else if (pick == 1) near = int'(hi) + int'($urandom_range(2));
          else near = int'(lo) + int'($urandom_range(span_i - 1));
          if (near < 0) near = 0;
          if (near > 65535) near = 65535;
          case (src)
            SRC_PH: begin
              it.ph = near[FIELD_W-1:0];
            end
            SRC_X: begin
              it.px = near[FIELD_W-1:0];
            end
            SRC_Y: begin
              it.py = near[FIELD_W-1:0];
            end
            default: begin
              it.wt = near[FIELD_W-1:0];
            end
          endcase
        end
      end
    end
    return it;
  endfunction

  // write all four registers while the block is idle
  task automatic apply_config(input logic [CFG_SRC_W-1:0] srcs,
                              input logic [CFG_DATA_W-1:0] lo, hi, nb);
    @(posedge clk);
    cfg_wr_en      <= 1'b1;
    cfg_index      <= CFG_SOURCES;
    cfg_wr_data    <= CFG_DATA_W'(srcs);
    mirror_sources = srcs;
    @(posedge clk);
    cfg_index    <= CFG_LOWER;
    cfg_wr_data  <= lo;
    mirror_lower = lo;
    @(posedge clk);
    cfg_index    <= CFG_UPPER;
    cfg_wr_data  <= hi;
    mirror_upper = hi;
    @(posedge clk);
    cfg_index    <= CFG_BINS;
    cfg_wr_data  <= nb;
    mirror_nbins = nb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // run the queued transactions to completion under one idle pattern
  task automatic run_phase(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    do @(negedge clk);
    while (pending_items.size() != 0 || item_ch.valid || due_results.size() != 0);
    // let the last counter update settle before registers change
    repeat (8) @(negedge clk);
  endtask

  // driver: present queued transactions, predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        queue_result(tally_item(on_wire));
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_wire                  = pending_items.pop_front();
          item_ch.valid            <= 1'b1;
          item_ch.kind             <= on_wire.kind;
          item_ch.sum_pulse_height <= on_wire.ph;
          item_ch.pixel_x          <= on_wire.px;
          item_ch.pixel_y          <= on_wire.py;
          item_ch.event_weight     <= on_wire.wt;
          item_ch.column_index     <= on_wire.col;
          item_ch.bin_index        <= on_wire.bin;
          item_ch.write_value      <= on_wire.wval;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result count %h hits %b sats %b", $time,
                   result_ch.read_count, result_ch.hit_mask, result_ch.saturated_mask);
          error_count++;
        end else begin
          want = due_results.pop_front();
          if (result_ch.read_count !== want.count) begin
            $display("%0t: read_count expected %h actual %h", $time,
                     want.count, result_ch.read_count);
            error_count++;
          end
          if (result_ch.hit_mask !== want.hits) begin
            $display("%0t: hit_mask expected %b actual %b", $time,
                     want.hits, result_ch.hit_mask);
            error_count++;
          end
          if (result_ch.saturated_mask !== want.sats) begin
            $display("%0t: saturated_mask expected %b actual %b", $time,
                     want.sats, result_ch.saturated_mask);
            error_count++;
          end
        end
      end
      result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_column_histogram_binner: mismatch");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [CFG_SRC_W-1:0]  s;
    logic [CFG_DATA_W-1:0] lo, hi, nb;
    int                    a, b, t, code;
    rst                        = 1'b1;
    cfg_wr_en                  = 1'b0;
    cfg_index                  = CFG_SOURCES;
    cfg_wr_data                = '0;
    item_ch.valid              = 1'b0;
    item_ch.kind               = KIND_EVENT;
    item_ch.sum_pulse_height   = '0;
    item_ch.pixel_x            = '0;
    item_ch.pixel_y            = '0;
    item_ch.event_weight       = '0;
    item_ch.column_index       = '0;
    item_ch.bin_index          = '0;
    item_ch.write_value        = '0;
    result_ch.ready            = 1'b0;
    mirror_sources             = SOURCES_RESET;
    mirror_lower               = '0;
    mirror_upper               = '0;
    mirror_nbins               = '0;
    foreach (mirror_counts[i]) mirror_counts[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: range edges, saturation, access to corner bins
    apply_config({SRC_WEIGHT, SRC_Y, SRC_X, SRC_PH},
                 {16'd5, 16'd1000, 16'd0, 16'd100},
                 {16'd4, 16'd1000, 16'hFFFF, 16'd1100},
                 {16'd8, 16'd16, 16'd2000, 16'd10});
    queue_item(event_item(16'd100, 16'd0, 16'd1000, 16'd5));
    queue_item(event_item(16'd99, 16'hFFFF, 16'd0, 16'd0));
    queue_item(event_item(16'd1099, 16'hFFFE, 16'hFFFF, 16'hFFFF));
    queue_item(event_item(16'd1100, 16'd64, 16'd999, 16'd4));
    queue_item(event_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_item(event_item(16'd0, 16'd0, 16'd0, 16'd0));
    queue_item(access_item(KIND_WRITE, 2'd0, 10'd0, 32'hFFFF_FFFF));
    queue_item(event_item(16'd150, 16'hFFFF, 16'd0, 16'd0));
    queue_item(access_item(KIND_READ, 2'd0, 10'd0, 32'd0));
    queue_item(access_item(KIND_WRITE, 2'd0, 10'd1, 32'hFFFF_FFFE));
    queue_item(event_item(16'd200, 16'hFFFF, 16'd0, 16'd0));
    queue_item(event_item(16'd299, 16'hFFFF, 16'd0, 16'd0));
    queue_item(access_item(KIND_READ, 2'd0, 10'd1, 32'd0));
    queue_item(access_item(KIND_READ, 2'd1, 10'd1023, 32'd0));
    queue_item(access_item(KIND_READ, 2'd1, 10'd0, 32'd0));
    queue_item(access_item(KIND_WRITE, 2'd3, 10'd1023, 32'h5A5A_A5A5));
    queue_item(access_item(KIND_READ, 2'd3, 10'd1023, 32'd0));
    queue_item(access_item(KIND_WRITE, 2'd2, 10'd512, 32'hFFFF_FFFF));
    queue_item(access_item(KIND_READ, 2'd2, 10'd512, 32'd0));
    queue_item(access_item(KIND_WRITE, 2'd0, 10'd500, 32'd0));
    queue_item(access_item(KIND_READ, 2'd0, 10'd500, 32'd0));
    queue_item(access_item(KIND_NOP, 2'd3, 10'd1023, 32'hFFFF_FFFF));
    queue_item(access_item(KIND_NOP, 2'd0, 10'd0, 32'd0));
    queue_item(access_item(KIND_READ, 2'd0, 10'd9, 32'd0));
    run_phase(0, 0);

    // zero bin count, unused sources, bin count above the maximum
    apply_config({SRC_WEIGHT, SRC_OFF_HI, SRC_OFF_LO, SRC_PH},
                 {16'd0, 16'd0, 16'd0, 16'd10},
                 {16'hFFFF, 16'd100, 16'd100, 16'd500},
                 {16'hFFFF, 16'd4, 16'd4, 16'd0});
    repeat (12) queue_item(make_item());
    run_phase(BOTH_PCT, BOTH_PCT);

    // random phases under varied settings and idle patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 1) begin
        s  = {SRC_WEIGHT, SRC_Y, SRC_X, SRC_PH};
        lo = '0;
        hi = '1;
        nb = '1;
      end else if (p == 3) begin
        s  = {SRC_PH, SRC_X, SRC_Y, SRC_WEIGHT};
        lo = {4{16'hFFFE}};
        hi = {4{16'hFFFF}};
        nb = {16'd1, 16'd2, 16'd1024, 16'd1};
      end else begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          code = ($urandom_range(6) == 0) ? $urandom_range(7, 4) : $urandom_range(3);
          s[SRC_W*c +: SRC_W] = code[SRC_W-1:0];
          a = $urandom_range(65535);
          b = $urandom_range(65535);
          case ($urandom_range(9))
            0: begin
              b = a;
            end
            1: begin
              if (a < b) begin
                t = a; a = b; b = t;
              end
            end
            2: begin
              a = $urandom_range(65534);
              b = a + 1 + $urandom_range(((65534 - a) < 40) ? (65534 - a) : 40);
            end
            default: begin
              if (a > b) begin
                t = a; a = b; b = t;
              end
              if (a == b) begin
                if (b == 65535) a = a - 1;
                else b = b + 1;
              end
            end
          endcase
          lo[PACK_W*c +: PACK_W] = a[PACK_W-1:0];
          hi[PACK_W*c +: PACK_W] = b[PACK_W-1:0];
          t = $urandom_range(9);
          if (t < 6) code = $urandom_range(8, 1);
          else if (t < 8) code = $urandom_range(1024, 9);
          else if (t == 8) code = $urandom_range(65535, 1025);
          else code = 0;
          nb[PACK_W*c +: PACK_W] = code[PACK_W-1:0];
        end
      end
      apply_config(s, lo, hi, nb);
      repeat (PHASE_ITEMS) queue_item(make_item());
      case (p % 4)
        0: run_phase(0, 0);
        1: run_phase(IDLE_PCT, 0);
        2: run_phase(0, IDLE_PCT);
        default: run_phase(BOTH_PCT, BOTH_PCT);
      endcase
    end

    // every register at all ones
    apply_config('1, '1, '1, '1);
    repeat (16) queue_item(make_item());
    run_phase(0, IDLE_PCT);

    repeat (64) @(negedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, due_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("multi_column_histogram_binner: match");
    end else begin
      $display("multi_column_histogram_binner: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/mchb_pkg.sv
design/mchb_if.sv
design/mchb_ctrl.sv
design/mchb_datapath.sv
design/multi_column_histogram_binner.sv
design/mchb_checker.sv
dv/multi_column_histogram_binner_tb.sv
